// File: design/vad_pkg.sv
// Shared constants, types and the level function of the voice activity detector.
package vad_pkg;

  // Frame length limit used when the top level is not overridden.
  localparam int unsigned MAX_FRAME_SAMPLES_DEF = 1024;

  // Configuration port geometry: five 32-bit registers at byte addresses 4*i.
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  // Register indexes (word address on the configuration port).
  localparam logic [2:0] REG_START_THR = 3'd0;
  localparam logic [2:0] REG_END_THR   = 3'd1;
  localparam logic [2:0] REG_START_FRM = 3'd2;
  localparam logic [2:0] REG_END_FRM   = 3'd3;
  localparam logic [2:0] REG_SEG_CAP   = 3'd4;

  // Register reset values.
  localparam logic [6:0]  RST_START_THR = 7'd30;
  localparam logic [6:0]  RST_END_THR   = 7'd20;
  localparam logic [15:0] RST_START_FRM = 16'd3;
  localparam logic [15:0] RST_END_FRM   = 16'd10;
  localparam logic [23:0] RST_SEG_CAP   = 24'd80000;

  // Largest magnitude a sample can contribute, and the percent scale.
  localparam logic [14:0] PEAK_MAX    = 15'h7fff;
  localparam logic [6:0]  LEVEL_SCALE = 7'd100;

  // Configuration register set.
  typedef struct packed {
    logic [6:0]  start_threshold;
    logic [6:0]  end_threshold;
    logic [15:0] start_frames;
    logic [15:0] end_frames;
    logic [23:0] seg_capacity;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [6:0]  level_pct;
    logic        speech_on;
    logic [15:0] segment_number;
    logic        start_event;
    logic        end_event;
    logic [23:0] segment_length;
  } result_t;

  // Level in percent: peak*100/32767. The divide by 2^15-1 takes the quotient
  // from the top bits and fixes it with a single compare, since the remainder
  // estimate always stays below twice the divisor.
  function automatic logic [6:0] level_of(input logic [14:0] peak);
    logic [21:0] prod;
    logic [6:0]  q0;
    logic [15:0] rem;
    prod = 22'(peak) * 22'(LEVEL_SCALE);
    q0   = prod[21:15];
    rem  = {1'b0, prod[14:0]} + {9'd0, q0};
    level_of = (rem >= {1'b0, PEAK_MAX}) ? q0 + 7'd1 : q0;
  endfunction

endpackage

// File: design/vad_frame_acc.sv
// Per-sample peak and sample count accumulation, with a register for each finished frame.
module vad_frame_acc #(
  parameter int unsigned MAX_FRAME_SAMPLES = vad_pkg::MAX_FRAME_SAMPLES_DEF,
  localparam int unsigned CNT_W = $clog2(MAX_FRAME_SAMPLES + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               smp_valid,
  input  logic signed [15:0] smp_data,
  input  logic               smp_last,
  output logic               smp_ready,
  output logic               frm_valid,
  output logic [14:0]        frm_peak,
  output logic [CNT_W-1:0]   frm_count,
  input  logic               frm_ready
);
  import vad_pkg::*;

  logic [14:0]      peak_r, peak_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             frm_valid_r;
  logic [14:0]      frm_peak_r;
  logic [CNT_W-1:0] frm_count_r;

  logic [15:0]      abs_val;
  logic [14:0]      mag;
  logic [14:0]      peak_upd;
  logic [CNT_W-1:0] cnt_inc;
  logic             frame_done;
  logic             slot_free;
  logic             take;

  // Magnitude of the sample, clamped so the most negative code gives 32767.
  always_comb begin
    abs_val  = smp_data[15] ? 16'(-smp_data) : 16'(smp_data);
    mag      = abs_val[15] ? PEAK_MAX : abs_val[14:0];
    peak_upd = (mag > peak_r) ? mag : peak_r;
    cnt_inc  = cnt_r + CNT_W'(1);
    // A frame also closes once it holds the maximum number of samples.
    frame_done = smp_last || (cnt_inc == CNT_W'(MAX_FRAME_SAMPLES));
  end

  // A sample is taken whenever the frame register can hold a possible result.
  assign slot_free = !frm_valid_r || frm_ready;
  assign take      = smp_valid && slot_free;
  assign smp_ready = slot_free;

  // Running values restart after the frame is handed on.
  always_comb begin
    peak_nxt = peak_r;
    cnt_nxt  = cnt_r;
    if (take) begin
      peak_nxt = frame_done ? '0 : peak_upd;
      cnt_nxt  = frame_done ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r      <= '0;
      cnt_r       <= '0;
      frm_valid_r <= 1'b0;
    end else begin
      peak_r <= peak_nxt;
      cnt_r  <= cnt_nxt;
      if (slot_free) begin
        frm_valid_r <= take && frame_done;
      end
    end
  end

  // Finished frame payload.
  always_ff @(posedge clk) begin
    if (take && frame_done) begin
      frm_peak_r  <= peak_upd;
      frm_count_r <= cnt_inc;
    end
  end

  assign frm_valid = frm_valid_r;
  assign frm_peak  = frm_peak_r;
  assign frm_count = frm_count_r;

endmodule

// File: design/vad_decide.sv
// Frame level smoothing, start/end hysteresis, segment capture and the result register.
module vad_decide #(
  parameter int unsigned MAX_FRAME_SAMPLES = vad_pkg::MAX_FRAME_SAMPLES_DEF,
  localparam int unsigned CNT_W = $clog2(MAX_FRAME_SAMPLES + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  vad_pkg::cfg_t         cfg,
  input  logic                  frm_valid,
  input  logic [14:0]           frm_peak,
  input  logic [CNT_W-1:0]      frm_count,
  output logic                  frm_ready,
  output logic                  out_valid,
  output vad_pkg::result_t      out_res,
  input  logic                  out_ready
);
  import vad_pkg::*;

  logic [6:0]  smooth_r, smooth_nxt;
  logic [15:0] loud_r, loud_nxt;
  logic [15:0] quiet_r, quiet_nxt;
  logic [15:0] segcnt_r, segcnt_nxt;
  logic        speech_r, speech_nxt;
  logic [23:0] capt_r, capt_nxt;
  logic        out_valid_r;
  result_t     res_r;

  logic [6:0]  level;
  logic [8:0]  smooth_sum;
  logic [15:0] loud_inc;
  logic [15:0] quiet_inc;
  logic        start_ev;
  logic        end_ev;
  logic [23:0] capt_base;
  logic [23:0] room;
  logic [23:0] cnt_ext;
  logic [23:0] capt_sum;
  logic        out_free;
  logic        take;

  assign out_free  = !out_valid_r || out_ready;
  assign take      = frm_valid && out_free;
  assign frm_ready = out_free;

  // Level of the frame and the 3:1 smoothing with the previous level.
  always_comb begin
    level      = level_of(frm_peak);
    smooth_sum = {2'b00, smooth_r} + {1'b0, smooth_r, 1'b0} + {2'b00, level};
    smooth_nxt = smooth_sum[8:2];
  end

  // Start/end hysteresis qualified by runs of loud or quiet frames.
  always_comb begin
    loud_inc   = loud_r + 16'd1;
    quiet_inc  = quiet_r + 16'd1;
    speech_nxt = speech_r;
    loud_nxt   = loud_r;
    quiet_nxt  = quiet_r;
    segcnt_nxt = segcnt_r;
    start_ev   = 1'b0;
    end_ev     = 1'b0;
    if (speech_r) begin
      if (smooth_nxt >= cfg.end_threshold) begin
        quiet_nxt = '0;
      end else begin
        quiet_nxt = quiet_inc;
        if (quiet_inc >= cfg.end_frames) begin
          speech_nxt = 1'b0;
          loud_nxt   = '0;
          quiet_nxt  = '0;
          segcnt_nxt = segcnt_r + 16'd1;
          end_ev     = 1'b1;
        end
      end
    end else begin
      if (smooth_nxt >= cfg.start_threshold) begin
        loud_nxt = loud_inc;
        if (loud_inc >= cfg.start_frames) begin
          speech_nxt = 1'b1;
          quiet_nxt  = '0;
          start_ev   = 1'b1;
        end
      end else begin
        loud_nxt = '0;
      end
    end
  end

  // Segment capture: the frame's samples are added while speech is on,
  // saturating at the capacity. A start clears the count first; an end
  // reports the count and then clears it.
  always_comb begin
    capt_base = start_ev ? '0 : capt_r;
    room      = cfg.seg_capacity - capt_base;
    cnt_ext   = 24'(frm_count);
    capt_sum  = capt_base;
    if (speech_nxt && (capt_base < cfg.seg_capacity)) begin
      capt_sum = capt_base + ((room > cnt_ext) ? cnt_ext : room);
    end
    capt_nxt = end_ev ? '0 : capt_sum;
  end

  // Detector state moves only when a frame transfers into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r    <= '0;
      loud_r      <= '0;
      quiet_r     <= '0;
      segcnt_r    <= '0;
      speech_r    <= 1'b0;
      capt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        smooth_r <= smooth_nxt;
        loud_r   <= loud_nxt;
        quiet_r  <= quiet_nxt;
        segcnt_r <= segcnt_nxt;
        speech_r <= speech_nxt;
        capt_r   <= capt_nxt;
      end
      if (out_free) begin
        out_valid_r <= frm_valid;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (take) begin
      res_r.level_pct      <= smooth_nxt;
      res_r.speech_on      <= speech_nxt;
      res_r.segment_number <= segcnt_nxt;
      res_r.start_event    <= start_ev;
      res_r.end_event      <= end_ev;
      res_r.segment_length <= capt_sum;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // A pending result always mirrors the detector state it was taken from.
  a_res_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.segment_number == segcnt_r) && (res_r.speech_on == speech_r)
                    && (res_r.level_pct == smooth_r))
    else $error("pending result differs from detector state");

  // Events agree with the speech flag of the same frame.
  a_event_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.start_event || res_r.end_event) |->
      (res_r.speech_on == res_r.start_event) && !(res_r.start_event && res_r.end_event))
    else $error("start or end event inconsistent with speech flag");

  // The smoothed level never leaves the percent range.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.level_pct <= LEVEL_SCALE))
    else $error("level above 100 percent");

  // The quiet run only counts while speech is on.
  a_quiet_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !speech_r |-> (quiet_r == 16'd0))
    else $error("quiet run nonzero while idle");

endmodule

// File: design/frame_level_voice_activity_detector.sv
// A frame's last sample passes the input register, the frame register and the result register.
// Throughput: one sample per cycle while out_ready is high; the peak and count registers and the
// detector registers each update once per cycle, so one-sample frames follow at full rate.
// Reset (rst_n low, synchronous): all run state cleared, speech idle, registers at their
// documented defaults, no result pending.
module frame_level_voice_activity_detector #(
  parameter int unsigned MAX_FRAME_SAMPLES = vad_pkg::MAX_FRAME_SAMPLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Sample channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [15:0]          in_pcm_sample,
  input  logic                        in_frame_end,
  // Result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [6:0]                  out_level_pct,
  output logic                        out_speech_on,
  output logic [15:0]                 out_segment_number,
  output logic                        out_start_event,
  output logic                        out_end_event,
  output logic [23:0]                 out_segment_length,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vad_pkg::APB_AW-1:0]  paddr,
  input  logic [vad_pkg::APB_DW-1:0]  pwdata,
  output logic [vad_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import vad_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);

  cfg_t               cfg_r;
  logic [2:0]         reg_idx;
  logic               reg_wr;

  logic               smp_valid_r;
  logic signed [15:0] smp_data_r;
  logic               smp_last_r;
  logic               smp_ready;

  logic               frm_valid;
  logic [14:0]        frm_peak;
  logic [CNT_W-1:0]   frm_count;
  logic               frm_ready;
  result_t            res;

  // Configuration registers: written on the access phase of a write transfer.
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_threshold <= RST_START_THR;
      cfg_r.end_threshold   <= RST_END_THR;
      cfg_r.start_frames    <= RST_START_FRM;
      cfg_r.end_frames      <= RST_END_FRM;
      cfg_r.seg_capacity    <= RST_SEG_CAP;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_START_THR: cfg_r.start_threshold <= pwdata[6:0];
        REG_END_THR:   cfg_r.end_threshold   <= pwdata[6:0];
        REG_START_FRM: cfg_r.start_frames    <= pwdata[15:0];
        REG_END_FRM:   cfg_r.end_frames      <= pwdata[15:0];
        REG_SEG_CAP:   cfg_r.seg_capacity    <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (reg_idx)
      REG_START_THR: prdata = APB_DW'(cfg_r.start_threshold);
      REG_END_THR:   prdata = APB_DW'(cfg_r.end_threshold);
      REG_START_FRM: prdata = APB_DW'(cfg_r.start_frames);
      REG_END_FRM:   prdata = APB_DW'(cfg_r.end_frames);
      REG_SEG_CAP:   prdata = APB_DW'(cfg_r.seg_capacity);
      default:       prdata = '0;
    endcase
  end

  // Input register: takes a new transfer when it is empty or its content moves on.
  assign in_ready = !smp_valid_r || smp_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
    end else if (in_ready) begin
      smp_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp_data_r <= in_pcm_sample;
      smp_last_r <= in_frame_end;
    end
  end

  vad_frame_acc #(
    .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
  ) u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .smp_valid (smp_valid_r),
    .smp_data  (smp_data_r),
    .smp_last  (smp_last_r),
    .smp_ready (smp_ready),
    .frm_valid (frm_valid),
    .frm_peak  (frm_peak),
    .frm_count (frm_count),
    .frm_ready (frm_ready)
  );

  vad_decide #(
    .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
  ) u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .frm_valid (frm_valid),
    .frm_peak  (frm_peak),
    .frm_count (frm_count),
    .frm_ready (frm_ready),
    .out_valid (out_valid),
    .out_res   (res),
    .out_ready (out_ready)
  );

  assign out_level_pct      = res.level_pct;
  assign out_speech_on      = res.speech_on;
  assign out_segment_number = res.segment_number;
  assign out_start_event    = res.start_event;
  assign out_end_event      = res.end_event;
  assign out_segment_length = res.segment_length;

endmodule
